// ===== rtl/lspq_pkg.sv =====
// shared types, constants and codes for the linear scan priority queue
package lspq_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int OCC_W = 7;

  typedef enum logic {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_LOAD,
    S_SHIFT
  } state_t;

  typedef struct packed {
    func_t       func;
    logic [15:0] entry_id;
    logic [7:0]  entry_priority;
  } cmd_t;

  typedef struct packed {
    status_t            status;
    logic [15:0]        served_id;
    logic [7:0]         served_priority;
    logic [OCC_W-1:0]   occupancy;
  } res_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
  } word_t;

  typedef struct packed {
    logic clear;
    logic sample;
  } track_ctl_t;

endpackage

// ===== rtl/lspq_min_track.sv =====
// running minimum of the scanned entries, earliest index kept on ties
module lspq_min_track
  import lspq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  track_ctl_t       ctl,
  input  logic [IDX_W-1:0] idx,
  input  word_t            word,
  output word_t            best_word,
  output logic [IDX_W-1:0] best_idx
);

  logic have;
  logic take;

  assign take = ctl.sample && (!have || (word.prio < best_word.prio));

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (ctl.clear) begin
      have <= 1'b0;
    end else if (ctl.sample) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !ctl.clear) begin
      best_word <= word;
      best_idx  <= idx;
    end
  end

endmodule

// ===== rtl/linear_scan_priority_queue.sv =====
// top level: store memory, scan and compaction sequencer
//
//  channel  signals              handshake
//  -------  -------------------  -------------------------------------
//  input    cmd (cmd_t)          beat taken when start && !busy
//  output   result (res_t)       beat shown one cycle with done high
//
// an enqueue gives its result the cycle after it is taken and busy stays low.
// a dequeue keeps busy high through two passes over the store, set by the single
// read port of the store: one pass reads all n held entries, a second moves the
// entries behind the winner down. its result follows in the first cycle with busy low.
// rst is synchronous and clears the count and sequencer; the store needs no clearing.
// the receiver cannot stall: each result is valid for its one cycle only.
module linear_scan_priority_queue
  import lspq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic done,
  output res_t result
);

  word_t mem [DEPTH];

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] ptr, ptr_next;
  logic [CNT_W-1:0] pend_ptr, pend_ptr_next;
  logic             pend, pend_next;
  logic             done_next;
  res_t             result_next;

  logic             rd_en;
  logic [CNT_W-1:0] rd_addr;
  word_t            rd_data;
  logic             wr_en;
  logic [CNT_W-1:0] wr_addr;
  word_t            wr_data;

  track_ctl_t       trk_ctl;
  word_t            best_word;
  logic [IDX_W-1:0] best_idx;

  lspq_min_track u_track (
    .clk       (clk),
    .rst       (rst),
    .ctl       (trk_ctl),
    .idx       (pend_ptr[IDX_W-1:0]),
    .word      (rd_data),
    .best_word (best_word),
    .best_idx  (best_idx)
  );

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr[IDX_W-1:0]];
    end
    if (wr_en) begin
      mem[wr_addr[IDX_W-1:0]] <= wr_data;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    count_next    = count;
    ptr_next      = ptr;
    pend_next     = pend;
    pend_ptr_next = pend_ptr;
    done_next     = 1'b0;
    result_next   = result;
    rd_en         = 1'b0;
    rd_addr       = ptr;
    wr_en         = 1'b0;
    wr_addr       = count;
    wr_data       = word_t'{id: cmd.entry_id, prio: cmd.entry_priority};
    trk_ctl       = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          result_next.served_id       = '0;
          result_next.served_priority = '0;
          unique case (cmd.func)
            FUNC_ENQ: begin
              done_next = 1'b1;
              if (count == CNT_W'(DEPTH)) begin
                result_next.status = ST_FULL;
              end else begin
                result_next.status = ST_DONE;
                wr_en      = 1'b1;
                count_next = count + CNT_W'(1);
              end
              result_next.occupancy = OCC_W'(count_next);
            end
            FUNC_DEQ: begin
              if (count == '0) begin
                done_next             = 1'b1;
                result_next.status    = ST_EMPTY;
                result_next.occupancy = '0;
              end else begin
                trk_ctl.clear = 1'b1;
                ptr_next      = '0;
                pend_next     = 1'b0;
                state_next    = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        trk_ctl.sample = pend;
        rd_en          = 1'b1;
        rd_addr        = ptr;
        pend_next      = 1'b1;
        pend_ptr_next  = ptr;
        ptr_next       = ptr + CNT_W'(1);
        if (ptr == count - CNT_W'(1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        trk_ctl.sample = pend;
        pend_next      = 1'b0;
        state_next     = S_LOAD;
      end
      S_LOAD: begin
        ptr_next   = CNT_W'(best_idx) + CNT_W'(1);
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = pend_ptr - CNT_W'(1);
          wr_data = rd_data;
        end
        if (ptr < count) begin
          rd_en         = 1'b1;
          rd_addr       = ptr;
          pend_next     = 1'b1;
          pend_ptr_next = ptr;
          ptr_next      = ptr + CNT_W'(1);
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            count_next                  = count - CNT_W'(1);
            done_next                   = 1'b1;
            result_next.status          = ST_DONE;
            result_next.served_id       = best_word.id;
            result_next.served_priority = best_word.prio;
            result_next.occupancy       = OCC_W'(count_next);
            state_next                  = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr      <= ptr_next;
    pend_ptr <= pend_ptr_next;
    result   <= result_next;
  end

endmodule

// ===== rtl/lspq_checker.sv =====
// port level checks for the linear scan priority queue, bound to the top level
module lspq_checker
  import lspq_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input cmd_t cmd,
  input logic done,
  input res_t result
);

  a_enq_next: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.func == FUNC_ENQ |=> done)
    else $error("enqueue not answered in the next cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ST_DONE |-> result.served_id == '0 && result.served_priority == '0)
    else $error("failed beat carries a served entry");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_FULL |-> result.occupancy == OCC_W'(DEPTH))
    else $error("full status with store not full");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_EMPTY |-> result.occupancy == '0)
    else $error("empty status with entries held");

endmodule

bind linear_scan_priority_queue lspq_checker u_lspq_checker (.*);
